// ===== design/baro_pkg.sv =====
// Shared types, constants and helpers for the barometric compensation core.
// No dependencies.
`default_nettype none
package baro_pkg;

  typedef logic signed [63:0] word_t;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegTemp   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSens   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffset = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNonlin = 3'd3;

  localparam int CfgDataW = 48;
  localparam int NumStages = 19;

  localparam logic signed [14:0] TempMin = -15'sd4000;
  localparam logic signed [14:0] TempMax = 15'sd8500;
  localparam logic [23:0] PressMin = 24'd3000000;
  localparam logic [23:0] PressMax = 24'd12500000;

  // Signed divide by 2^k, truncating toward zero.
  function automatic word_t sdiv2(input word_t x, input int unsigned k);
    word_t bias;
    bias = (64'sd1 <<< k) - 64'sd1;
    return x[63] ? ((x + bias) >>> k) : (x >>> k);
  endfunction

endpackage
`default_nettype wire

// ===== design/barometric_compensation_core.sv =====
// Barometric compensation core: 64-bit integer temperature and pressure compensation.
// Fully pipelined; throughput one item per cycle while no result waits on out_ready.
// The whole pipeline advances together; it holds while a result waits on out_ready.
// Synchronous active-low reset clears the valid bits and the four coefficient
// registers (all zero); payload registers are not reset. Depends on baro_pkg.
`default_nettype none
module barometric_compensation_core
  import baro_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CfgDataW-1:0]   cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [23:0]           in_raw_temp,
  input  wire logic [23:0]           in_raw_press,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [14:0]         out_temp_centi_c,
  output logic [23:0]                out_press_centi_pa,
  output logic                       out_clamped
);

  // Coefficient registers, to be written only while idle; the block itself does not enforce this.
  logic [39:0] temp_coeffs_r;
  logic [47:0] sens_coeffs_r;
  logic [47:0] offset_coeffs_r;
  logic [31:0] nonlin_coeffs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r   <= '0;
      sens_coeffs_r   <= '0;
      offset_coeffs_r <= '0;
      nonlin_coeffs_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegTemp:   temp_coeffs_r   <= cfg_wdata[39:0];
        RegSens:   sens_coeffs_r   <= cfg_wdata;
        RegOffset: offset_coeffs_r <= cfg_wdata;
        RegNonlin: nonlin_coeffs_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficients; unsigned fields get a zero sign bit.
  logic [15:0]        t1;
  logic signed [16:0] t2, p5, p6;
  logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p1, p2, p9;
  assign t1  = temp_coeffs_r[39:24];
  assign t2  = $signed({1'b0, temp_coeffs_r[23:8]});
  assign t3  = $signed(temp_coeffs_r[7:0]);
  assign p1  = $signed(sens_coeffs_r[47:32]);
  assign p2  = $signed(sens_coeffs_r[31:16]);
  assign p3  = $signed(sens_coeffs_r[15:8]);
  assign p4  = $signed(sens_coeffs_r[7:0]);
  assign p5  = $signed({1'b0, offset_coeffs_r[47:32]});
  assign p6  = $signed({1'b0, offset_coeffs_r[31:16]});
  assign p7  = $signed(offset_coeffs_r[15:8]);
  assign p8  = $signed(offset_coeffs_r[7:0]);
  assign p9  = $signed(nonlin_coeffs_r[31:16]);
  assign p10 = $signed(nonlin_coeffs_r[15:8]);
  assign p11 = $signed(nonlin_coeffs_r[7:0]);

  // Global advance: every stage moves when the output slot is free or taken.
  logic [NumStages:1] vld_r;
  logic en;
  assign en       = !vld_r[NumStages] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NumStages-1:1], in_valid};
    end
  end

  // Delay lines for values used far down the pipe.
  logic [23:0]        rp_pipe_r   [1:14];
  logic signed [29:0] tlin_pipe_r [5:7];
  logic signed [14:0] temp_pipe_r [7:NumStages];
  logic               tcl_pipe_r  [7:NumStages];

  // Stage registers
  logic signed [25:0] s1_at_r;
  word_t s2_b_r, s2_c_r, s3_b_r, s3_d_r, s4_e_r;
  word_t s6_tsq_r, s6_t25_r, s6_foff_r, s6_esens_r, s6_pb_r;
  word_t s7_bq_r, s7_eoff_r, s7_dsens_r, s7_pc_r, s7_foff_r, s7_esens_r;
  word_t s8_btlo_r, s8_bthi_r, s8_cr_r, s8_rr_r;
  word_t s8_eoff_r, s8_dsens_r, s8_foff_r, s8_esens_r;
  word_t s9_bt_r, s9_dr_r, s9_pf_r, s9_eoff_r, s9_dsens_r, s9_foff_r, s9_esens_r;
  word_t s10_cq_r, s10_er_r, s10_pfq_r, s10_eoff_r, s10_dsens_r, s10_foff_r, s10_esens_r;
  word_t s11_doff_r, s11_bsens_r, s11_er2_r, s11_cr_r;
  word_t s11_eoff_r, s11_dsens_r, s11_foff_r, s11_esens_r;
  word_t s12_offa_r, s12_offb_r, s12_sensa_r, s12_sensb_r, s12_c2_r, s12_er2_r;
  word_t s13_off_r, s13_sens_r, s13_c2_r, s13_er2_r;
  word_t s14_off4_r, s14_sq_r, s14_c2_r, s14_er2_r;
  word_t s15_off4_r, s15_am_r, s15_c2_r, s15_er2_r;
  word_t s16_suma_r, s16_sumb_r, s17_sum_r, s18_s25_r;
  logic [23:0] s19_press_r;
  logic        s19_pcl_r;

  // Temperature clamp in stage 7
  word_t tq;
  logic signed [14:0] temp_nxt;
  logic tcl_nxt;
  assign tq = sdiv2(s6_t25_r, 14);
  always_comb begin
    temp_nxt = tq[14:0];
    tcl_nxt  = 1'b0;
    if (tq < 64'(TempMin)) begin
      temp_nxt = TempMin;
      tcl_nxt  = 1'b1;
    end else if (tq > 64'(TempMax)) begin
      temp_nxt = TempMax;
      tcl_nxt  = 1'b1;
    end
  end

  // Pressure clamp in stage 19; the sum is read as unsigned after scaling.
  logic [23:0] press_raw, press_nxt;
  logic pcl_nxt;
  assign press_raw = s18_s25_r[63:40];
  always_comb begin
    press_nxt = press_raw;
    pcl_nxt   = 1'b0;
    if (press_raw < PressMin) begin
      press_nxt = PressMin;
      pcl_nxt   = 1'b1;
    end else if (press_raw > PressMax) begin
      press_nxt = PressMax;
      pcl_nxt   = 1'b1;
    end
  end

  // Linearized temperature from stage 4; it fits in 30 signed bits.
  word_t tlin_full;
  assign tlin_full = sdiv2(s4_e_r, 32);

  word_t tl6, tl8, rp8, rp10, rp11, rp15;
  assign tl6  = 64'(tlin_pipe_r[5]);
  assign tl8  = 64'(tlin_pipe_r[7]);
  assign rp8  = $signed({40'd0, rp_pipe_r[7]});
  assign rp10 = $signed({40'd0, rp_pipe_r[9]});
  assign rp11 = $signed({40'd0, rp_pipe_r[10]});
  assign rp15 = $signed({40'd0, rp_pipe_r[14]});

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: take the item, offset the temperature sample
      s1_at_r      <= $signed({2'b00, in_raw_temp}) - $signed({2'b00, t1, 8'd0});
      rp_pipe_r[1] <= in_raw_press;
      for (int i = 2; i <= 14; i++) rp_pipe_r[i] <= rp_pipe_r[i-1];
      // stages 2-5: linearised temperature
      s2_b_r <= 64'(s1_at_r) * 64'(t2);
      s2_c_r <= 64'(s1_at_r) * 64'(s1_at_r);
      s3_b_r <= s2_b_r;
      s3_d_r <= s2_c_r * 64'(t3);
      s4_e_r <= (s3_b_r <<< 18) + s3_d_r;
      tlin_pipe_r[5] <= tlin_full[29:0];
      for (int i = 6; i <= 7; i++) tlin_pipe_r[i] <= tlin_pipe_r[i-1];
      // stage 6: products of t_lin
      s6_tsq_r   <= tl6 * tl6;
      s6_t25_r   <= tl6 * 64'sd25;
      s6_foff_r  <= tl6 * 64'(p6);
      s6_esens_r <= tl6 * (64'(p2) - 64'sd16384);
      s6_pb_r    <= tl6 * 64'(p10);
      // stage 7: temperature result, scale terms
      temp_pipe_r[7] <= temp_nxt;
      tcl_pipe_r[7]  <= tcl_nxt;
      for (int i = 8; i <= NumStages; i++) begin
        temp_pipe_r[i] <= temp_pipe_r[i-1];
        tcl_pipe_r[i]  <= tcl_pipe_r[i-1];
      end
      s7_bq_r    <= sdiv2(s6_tsq_r, 6);
      s7_eoff_r  <= (s6_tsq_r * 64'(p7)) <<< 4;
      s7_dsens_r <= (s6_tsq_r * 64'(p3)) <<< 2;
      s7_pc_r    <= s6_pb_r + (64'(p9) <<< 16);
      s7_foff_r  <= s6_foff_r <<< 22;
      s7_esens_r <= s6_esens_r <<< 21;
      // stage 8: split cube product, raw pressure products
      s8_btlo_r  <= $signed({38'd0, s7_bq_r[25:0]}) * tl8;
      s8_bthi_r  <= $signed({38'd0, s7_bq_r[51:26]}) * tl8;
      s8_cr_r    <= s7_pc_r * rp8;
      s8_rr_r    <= rp8 * rp8;
      s8_eoff_r  <= s7_eoff_r;
      s8_dsens_r <= s7_dsens_r;
      s8_foff_r  <= s7_foff_r;
      s8_esens_r <= s7_esens_r;
      // stage 9
      s9_bt_r    <= s8_btlo_r + (s8_bthi_r <<< 26);
      s9_dr_r    <= sdiv2(s8_cr_r, 13);
      s9_pf_r    <= s8_rr_r * 64'(p11);
      s9_eoff_r  <= s8_eoff_r;
      s9_dsens_r <= s8_dsens_r;
      s9_foff_r  <= s8_foff_r;
      s9_esens_r <= s8_esens_r;
      // stage 10
      s10_cq_r    <= sdiv2(s9_bt_r, 8);
      s10_er_r    <= s9_dr_r * rp10;
      s10_pfq_r   <= sdiv2(s9_pf_r, 16);
      s10_eoff_r  <= s9_eoff_r;
      s10_dsens_r <= s9_dsens_r;
      s10_foff_r  <= s9_foff_r;
      s10_esens_r <= s9_esens_r;
      // stage 11
      s11_doff_r  <= sdiv2(s10_cq_r * 64'(p8), 5);
      s11_bsens_r <= sdiv2(s10_cq_r * 64'(p4), 5);
      s11_er2_r   <= sdiv2(s10_er_r, 9);
      s11_cr_r    <= s10_pfq_r * rp11;
      s11_eoff_r  <= s10_eoff_r;
      s11_dsens_r <= s10_dsens_r;
      s11_foff_r  <= s10_foff_r;
      s11_esens_r <= s10_esens_r;
      // stages 12-13: offset and sensitivity sums
      s12_offa_r  <= s11_doff_r + s11_eoff_r;
      s12_offb_r  <= (64'(p5) <<< 47) + s11_foff_r;
      s12_sensa_r <= s11_bsens_r + s11_dsens_r;
      s12_sensb_r <= ((64'(p1) - 64'sd16384) <<< 46) + s11_esens_r;
      s12_c2_r    <= sdiv2(s11_cr_r, 7);
      s12_er2_r   <= s11_er2_r;
      s13_off_r   <= s12_offa_r + s12_offb_r;
      s13_sens_r  <= s12_sensa_r + s12_sensb_r;
      s13_c2_r    <= s12_c2_r;
      s13_er2_r   <= s12_er2_r;
      // stages 14-18: combine
      s14_off4_r  <= sdiv2(s13_off_r, 2);
      s14_sq_r    <= sdiv2(s13_sens_r, 24);
      s14_c2_r    <= s13_c2_r;
      s14_er2_r   <= s13_er2_r;
      s15_off4_r  <= s14_off4_r;
      s15_am_r    <= s14_sq_r * rp15;
      s15_c2_r    <= s14_c2_r;
      s15_er2_r   <= s14_er2_r;
      s16_suma_r  <= s15_off4_r + s15_am_r;
      s16_sumb_r  <= s15_er2_r + s15_c2_r;
      s17_sum_r   <= s16_suma_r + s16_sumb_r;
      s18_s25_r   <= (s17_sum_r <<< 4) + (s17_sum_r <<< 3) + s17_sum_r;
      // stage 19: output register
      s19_press_r <= press_nxt;
      s19_pcl_r   <= pcl_nxt;
    end
  end

  assign out_valid          = vld_r[NumStages];
  assign out_temp_centi_c   = temp_pipe_r[NumStages];
  assign out_press_centi_pa = s19_press_r;
  assign out_clamped        = tcl_pipe_r[NumStages] | s19_pcl_r;

  // Checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

  a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_press_centi_pa >= PressMin && out_press_centi_pa <= PressMax))
    else $error("pressure out of range");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temp_centi_c >= TempMin && out_temp_centi_c <= TempMax))
    else $error("temperature out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[1])
    else $error("accepted item did not enter the pipe");

endmodule
`default_nettype wire
